// ===== hw/rtl/lntw_pkg.sv =====
// Shared types, constants and helpers for the LCD number-to-text writer.
// Used by lntw_ctrl, lntw_datapath and lcd_number_to_text_writer_core.
package lntw_pkg;

  // Default parameter values
  localparam int DEF_MAX_DIGITS  = 16;
  localparam int DEF_VALUE_WIDTH = 16;
  localparam int DEF_LINE_LENGTH = 40;

  // Fixed field widths of the request port
  localparam int COMMAND_W  = 2;
  localparam int COLUMN_W   = 6;
  localparam int VALUE_W    = 16;
  localparam int COUNT_IN_W = 5;

  // Number formats
  localparam logic [COMMAND_W-1:0] FMT_UDEC = 2'd0;
  localparam logic [COMMAND_W-1:0] FMT_SDEC = 2'd1;
  localparam logic [COMMAND_W-1:0] FMT_HEX  = 2'd2;
  localparam logic [COMMAND_W-1:0] FMT_BIN  = 2'd3;

  // LCD instruction and character codes
  localparam logic [7:0] CMD_SET_ADDR    = 8'h80;
  localparam logic [6:0] LINE_TWO_OFFSET = 7'h40;
  localparam logic [7:0] ASCII_ZERO      = 8'h30;
  localparam logic [7:0] ASCII_A         = 8'h41;
  localparam logic [7:0] ASCII_MINUS     = 8'h2D;
  localparam logic [7:0] ASCII_PLUS      = 8'h2B;

  // floor(v / 10) == (v * RECIP_10) >> RECIP_SHIFT for every v below 2^32
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // Which byte the datapath places in the output register
  typedef enum logic [1:0] {
    SEL_ADDR,
    SEL_SIGN,
    SEL_DIGIT
  } lntw_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      load;   // capture a new request
    logic      mul;    // form the reciprocal product
    logic      div;    // store one digit, reduce the value
    logic      emit;   // load the output register
    lntw_sel_t sel;
    logic      last;
  } lntw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic conv_done;   // all digits stored
    logic no_digits;   // digit count is zero
    logic has_sign;    // signed decimal request
    logic last_digit;  // next digit out is the final one
    logic out_free;    // output register can take a byte
  } lntw_stat_t;

  // Map a digit value to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] dx;
    dx = {4'b0000, d};
    if (d >= 4'd10) begin
      return ASCII_A + dx - 8'd10;
    end
    return ASCII_ZERO + dx;
  endfunction

endpackage

// ===== hw/rtl/lcd_number_to_text_writer_core.sv =====
// Top level of the LCD number-to-text writer: controller plus datapath.
// Depends on lntw_pkg, lntw_ctrl and lntw_datapath.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_ready   command, second_line, column,
//                                             value_bits, digit_count
//   out      output     out_valid / out_ready register_select, bus_byte,
//                                             last_of_run
//
// One request at a time. After acceptance the digits are extracted least
// significant first, each by a multiply step then a store step (for decimal,
// reciprocal multiply, then remainder); once all are stored the address byte
// is loaded into the output register. Bytes then leave one per cycle while
// out_ready is high: address, optional sign, digits.
// A stalled out_ready holds the output register and pauses the run.
// Synchronous active-high reset clears the state machine and out_valid.
module lcd_number_to_text_writer_core #(
  parameter int MAX_DIGITS  = lntw_pkg::DEF_MAX_DIGITS,
  parameter int VALUE_WIDTH = lntw_pkg::DEF_VALUE_WIDTH,
  parameter int LINE_LENGTH = lntw_pkg::DEF_LINE_LENGTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lntw_pkg::COMMAND_W-1:0]  command,
  input  logic                            second_line,
  input  logic [lntw_pkg::COLUMN_W-1:0]   column,
  input  logic [lntw_pkg::VALUE_W-1:0]    value_bits,
  input  logic [lntw_pkg::COUNT_IN_W-1:0] digit_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            register_select,
  output logic [7:0]                      bus_byte,
  output logic                            last_of_run
);
  import lntw_pkg::*;

  lntw_cmd_t  cmd;
  lntw_stat_t stat;

  // Sequencer
  lntw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Digit extraction and output register
  lntw_datapath #(
    .MAX_DIGITS  (MAX_DIGITS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .LINE_LENGTH (LINE_LENGTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .command         (command),
    .second_line     (second_line),
    .column          (column),
    .value_bits      (value_bits),
    .digit_count     (digit_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .register_select (register_select),
    .bus_byte        (bus_byte),
    .last_of_run     (last_of_run)
  );

endmodule

// ===== hw/rtl/lntw_ctrl.sv =====
// Sequencing state machine for the LCD number-to-text writer.
// Depends on lntw_pkg for the command and status structs.
module lntw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lntw_pkg::lntw_stat_t stat,
  output lntw_pkg::lntw_cmd_t  cmd
);
  import lntw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_ADDR,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  state_t state;
  state_t state_next;

  // Accept a request only between runs
  assign in_ready = (state == ST_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sel    = SEL_ADDR;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (stat.conv_done) begin
          state_next = ST_ADDR;
        end else begin
          cmd.mul    = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div    = 1'b1;
        state_next = ST_MUL;
      end
      ST_ADDR: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_ADDR;
          cmd.last = stat.no_digits && !stat.has_sign;
          if (stat.has_sign) begin
            state_next = ST_SIGN;
          end else if (stat.no_digits) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_DIGIT;
          end
        end
      end
      ST_SIGN: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_SIGN;
          cmd.last   = stat.no_digits;
          state_next = stat.no_digits ? ST_IDLE : ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_DIGIT;
          cmd.last = stat.last_digit;
          if (stat.last_digit) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/lntw_datapath.sv =====
// Datapath for the LCD number-to-text writer: request registers, digit
// extraction, digit buffer and output register. Depends on lntw_pkg.
module lntw_datapath #(
  parameter int MAX_DIGITS  = lntw_pkg::DEF_MAX_DIGITS,
  parameter int VALUE_WIDTH = lntw_pkg::DEF_VALUE_WIDTH,
  parameter int LINE_LENGTH = lntw_pkg::DEF_LINE_LENGTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lntw_pkg::lntw_cmd_t                 cmd,
  output lntw_pkg::lntw_stat_t                stat,
  input  logic [lntw_pkg::COMMAND_W-1:0]      command,
  input  logic                                second_line,
  input  logic [lntw_pkg::COLUMN_W-1:0]       column,
  input  logic [lntw_pkg::VALUE_W-1:0]        value_bits,
  input  logic [lntw_pkg::COUNT_IN_W-1:0]     digit_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                register_select,
  output logic [7:0]                          bus_byte,
  output logic                                last_of_run
);
  import lntw_pkg::*;

  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int PROD_W = VALUE_WIDTH + 32;

  // Request registers
  logic [COMMAND_W-1:0]   fmt;
  logic [7:0]             addr_byte;
  logic                   neg;
  logic                   has_sign;
  logic [VALUE_WIDTH-1:0] val;
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       idx;
  logic [PROD_W-1:0]      prod;
  logic [3:0]             digits [MAX_DIGITS];

  // Request decode
  logic [VALUE_W+VALUE_WIDTH-1:0] val_ext;
  logic [VALUE_WIDTH-1:0]         val_in;
  logic                           neg_in;
  logic [6:0]                     col_sat;
  logic [6:0]                     addr_in;
  logic [5:0]                     cnt_sat;
  logic                           is_dec_in;

  always_comb begin
    val_ext   = {{VALUE_WIDTH{1'b0}}, value_bits};
    val_in    = val_ext[VALUE_WIDTH-1:0];
    is_dec_in = (command == FMT_UDEC) || (command == FMT_SDEC);
    neg_in    = (command == FMT_SDEC) && val_in[VALUE_WIDTH-1];

    // Clamp column to 1..LINE_LENGTH
    if (column == '0) begin
      col_sat = 7'd1;
    end else if ({1'b0, column} > 7'(LINE_LENGTH)) begin
      col_sat = 7'(LINE_LENGTH);
    end else begin
      col_sat = {1'b0, column};
    end
    addr_in = (col_sat - 7'd1) + (second_line ? LINE_TWO_OFFSET : 7'd0);

    // Clamp digit count; decimal prints at least one digit
    if ({1'b0, digit_count} > 6'(MAX_DIGITS)) begin
      cnt_sat = 6'(MAX_DIGITS);
    end else begin
      cnt_sat = {1'b0, digit_count};
    end
    if (is_dec_in && (cnt_sat == 6'd0)) begin
      cnt_sat = 6'd1;
    end
  end

  // One digit step
  logic [PROD_W-1:0]      q_full;
  logic [VALUE_WIDTH-1:0] q_dec;
  logic [VALUE_WIDTH-1:0] ten_q;
  logic [VALUE_WIDTH-1:0] rem_dec;
  logic [3:0]             dig_new;
  logic [VALUE_WIDTH-1:0] val_new;

  always_comb begin
    q_full  = prod >> RECIP_SHIFT;
    q_dec   = q_full[VALUE_WIDTH-1:0];
    ten_q   = (q_dec << 3) + (q_dec << 1);
    rem_dec = val - ten_q;
    case (fmt)
      FMT_HEX: begin
        dig_new = val[3:0];
        val_new = val >> 4;
      end
      FMT_BIN: begin
        dig_new = {3'b000, val[0]};
        val_new = val >> 1;
      end
      default: begin
        dig_new = rem_dec[3:0];
        val_new = q_dec;
      end
    endcase
  end

  // Digit read, most significant first
  logic [CNT_W-1:0] rd_idx;
  logic [7:0]       digit_byte;

  always_comb begin
    rd_idx     = idx - CNT_W'(1);
    digit_byte = digit_char(digits[rd_idx[IDX_W-1:0]]);
  end

  // Status to the controller
  always_comb begin
    stat.conv_done  = (idx == cnt);
    stat.no_digits  = (cnt == '0);
    stat.has_sign   = has_sign;
    stat.last_digit = (idx == CNT_W'(1));
    stat.out_free   = !out_valid || out_ready;
  end

  // Capture request, run conversion, walk digits back out
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fmt       <= command;
      addr_byte <= CMD_SET_ADDR | {1'b0, addr_in};
      neg       <= neg_in;
      has_sign  <= (command == FMT_SDEC);
      val       <= neg_in ? (~val_in + VALUE_WIDTH'(1)) : val_in;
      cnt       <= cnt_sat[CNT_W-1:0];
      idx       <= '0;
    end else if (cmd.div) begin
      digits[idx[IDX_W-1:0]] <= dig_new;
      val                    <= val_new;
      idx                    <= idx + CNT_W'(1);
    end else if (cmd.emit && (cmd.sel == SEL_DIGIT)) begin
      idx <= rd_idx;
    end
    if (cmd.mul) begin
      prod <= {32'd0, val} * {{VALUE_WIDTH{1'b0}}, RECIP_10};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last_of_run <= cmd.last;
      unique case (cmd.sel)
        SEL_ADDR: begin
          register_select <= 1'b0;
          bus_byte        <= addr_byte;
        end
        SEL_SIGN: begin
          register_select <= 1'b1;
          bus_byte        <= neg ? ASCII_MINUS : ASCII_PLUS;
        end
        SEL_DIGIT: begin
          register_select <= 1'b1;
          bus_byte        <= digit_byte;
        end
        default: begin
          register_select <= 1'b0;
          bus_byte        <= addr_byte;
        end
      endcase
    end
  end

endmodule
